>>> hdl/pma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pma_pkg
// Shared types and constants for the PS/2 mouse packet accumulator.
// ----------------------------------------------------------------------------
package pma_pkg;

    typedef enum logic {
        OP_RX_BYTE = 1'b0,
        OP_QUERY   = 1'b1
    } t_op;

    // Position of the next byte within a three-byte packet
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } t_byte_pos;

    // Header byte bit positions
    localparam int unsigned HdrBtnLeft  = 0;
    localparam int unsigned HdrBtnRight = 1;
    localparam int unsigned HdrSync     = 3;
    localparam int unsigned HdrXSign    = 4;
    localparam int unsigned HdrYSign    = 5;

    localparam int unsigned OutWidth = 16;

    // Per-packet motion limit
    localparam logic signed [8:0] MotionMax = 9'sd127;
    localparam logic signed [8:0] MotionMin = -9'sd127;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic       from_aux;
    } t_in_item;

    typedef struct packed {
        logic                       data_valid;
        logic signed [OutWidth-1:0] delta_x;
        logic signed [OutWidth-1:0] delta_y;
        logic                       button_left;
        logic                       button_right;
    } t_out_item;

    // Clamp a 9-bit signed motion value to the per-packet limit
    function automatic logic signed [7:0] clamp_motion(input logic signed [8:0] v);
        logic signed [8:0] c;
        if (v > MotionMax) begin
            c = MotionMax;
        end else if (v < MotionMin) begin
            c = MotionMin;
        end else begin
            c = v;
        end
        return c[7:0];
    endfunction

endpackage

>>> hdl/pma_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pma_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface pma_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ps2_mouse_packet_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_accumulator
// Frames three-byte PS/2 mouse packets and accumulates their motion.
// ----------------------------------------------------------------------------
// Every transaction on i_in is either a received controller byte or a query.
// Bytes not flagged as auxiliary-port data restart the framing and are
// dropped; a first byte without the sync bit (bit 3) is dropped as well.
// When the third byte of a packet lands, X and Y are sign-extended with the
// header sign bits, Y is inverted so that screen-down is positive, each is
// clamped to +/-127 and added into saturating ACC_WIDTH-bit accumulators;
// the two button bits are latched and a pending flag is set. A query yields
// exactly one result transaction on o_out: with a packet pending it reports
// the accumulated motion (saturated to 16 bits) and the latched buttons, then
// clears motion and the pending flag (buttons are kept); with nothing pending
// it reports all zeros and leaves the state alone. Received bytes produce no
// result. Throughput is one transaction per clock: all decode, clamp and
// saturating-add logic is combinational on the registered state, and a query
// result appears in the output register the cycle after it is accepted.
// i_in.ready drops only while a result sits in the output register and
// o_out.ready is low.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_accumulator import pma_pkg::*; #(
    parameter int ACC_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pma_stream_if.sink          i_in,
    pma_stream_if.source        o_out
);

    // Framing state
    t_byte_pos r_byte_idx;
    t_byte_pos n_byte_idx;
    logic [7:0] r_header;
    logic [7:0] n_header;
    logic [7:0] r_x_byte;
    logic [7:0] n_x_byte;

    // Accumulated state
    logic signed [ACC_WIDTH-1:0] r_sum_x;
    logic signed [ACC_WIDTH-1:0] n_sum_x;
    logic signed [ACC_WIDTH-1:0] r_sum_y;
    logic signed [ACC_WIDTH-1:0] n_sum_y;
    logic r_left;
    logic n_left;
    logic r_right;
    logic n_right;
    logic r_pending;
    logic n_pending;

    // Output register
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic                        w_accept;
    t_in_item                    w_in;
    logic signed [ACC_WIDTH-1:0] w_pkt_sum_x;
    logic signed [ACC_WIDTH-1:0] w_pkt_sum_y;
    logic signed [OutWidth-1:0]  w_rep_x;
    logic signed [OutWidth-1:0]  w_rep_y;

    // Accept while the output register is free or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in       = i_in.data;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Motion of the packet completed by the current byte (used as Y byte)
    pma_motion #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_motion (
        .i_header (r_header),
        .i_x_byte (r_x_byte),
        .i_y_byte (w_in.rx_byte),
        .i_sum_x  (r_sum_x),
        .i_sum_y  (r_sum_y),
        .o_sum_x  (w_pkt_sum_x),
        .o_sum_y  (w_pkt_sum_y)
    );

    // Report width: sign-extend narrow accumulators, saturate wide ones
    if (ACC_WIDTH <= OutWidth) begin : g_rep_extend
        assign w_rep_x = OutWidth'(r_sum_x);
        assign w_rep_y = OutWidth'(r_sum_y);
    end else begin : g_rep_saturate
        localparam logic signed [ACC_WIDTH-1:0] RepMax = ACC_WIDTH'(32767);
        localparam logic signed [ACC_WIDTH-1:0] RepMin = -ACC_WIDTH'(32768);
        assign w_rep_x = (r_sum_x > RepMax) ? 16'sh7fff :
                         (r_sum_x < RepMin) ? 16'sh8000 : r_sum_x[OutWidth-1:0];
        assign w_rep_y = (r_sum_y > RepMax) ? 16'sh7fff :
                         (r_sum_y < RepMin) ? 16'sh8000 : r_sum_y[OutWidth-1:0];
    end

    always_comb begin
        n_byte_idx  = r_byte_idx;
        n_header    = r_header;
        n_x_byte    = r_x_byte;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_left      = r_left;
        n_right     = r_right;
        n_pending   = r_pending;
        n_out       = r_out;
        // Release the result once the sink takes it
        n_out_valid = r_out_valid && !o_out.ready;

        if (w_accept) begin
            if (w_in.op == OP_QUERY) begin
                n_out_valid = 1'b1;
                n_out       = '0;
                if (r_pending) begin
                    // Report, then clear motion and the flag; keep buttons
                    n_out.data_valid   = 1'b1;
                    n_out.delta_x      = w_rep_x;
                    n_out.delta_y      = w_rep_y;
                    n_out.button_left  = r_left;
                    n_out.button_right = r_right;
                    n_sum_x            = '0;
                    n_sum_y            = '0;
                    n_pending          = 1'b0;
                end
            end else if (!w_in.from_aux) begin
                // Keyboard or other traffic: restart framing, drop the byte
                n_byte_idx = POS_HEADER;
            end else begin
                unique case (r_byte_idx)
                    POS_X: begin
                        n_x_byte   = w_in.rx_byte;
                        n_byte_idx = POS_Y;
                    end
                    POS_Y: begin
                        n_sum_x    = w_pkt_sum_x;
                        n_sum_y    = w_pkt_sum_y;
                        n_left     = r_header[HdrBtnLeft];
                        n_right    = r_header[HdrBtnRight];
                        n_pending  = 1'b1;
                        n_byte_idx = POS_HEADER;
                    end
                    default: begin
                        // Header slot: hold off until a byte with sync set
                        if (w_in.rx_byte[HdrSync]) begin
                            n_header   = w_in.rx_byte;
                            n_byte_idx = POS_X;
                        end else begin
                            n_byte_idx = POS_HEADER;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx  <= POS_HEADER;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_byte_idx  <= n_byte_idx;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_left      <= n_left;
            r_right     <= n_right;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_header <= n_header;
        r_x_byte <= n_x_byte;
        r_out    <= n_out;
    end

endmodule

>>> hdl/pma_motion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pma_motion
// Decode packet motion, clamp it and add it into saturating accumulators.
// ----------------------------------------------------------------------------
module pma_motion import pma_pkg::*; #(
    parameter int ACC_WIDTH = 16
) (
    input  logic        [7:0]           i_header,
    input  logic        [7:0]           i_x_byte,
    input  logic        [7:0]           i_y_byte,
    input  logic signed [ACC_WIDTH-1:0] i_sum_x,
    input  logic signed [ACC_WIDTH-1:0] i_sum_y,
    output logic signed [ACC_WIDTH-1:0] o_sum_x,
    output logic signed [ACC_WIDTH-1:0] o_sum_y
);

    localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [7:0]         w_dx;
    logic signed [7:0]         w_dy;
    logic signed [ACC_WIDTH:0] w_add_x;
    logic signed [ACC_WIDTH:0] w_add_y;

    // Clamp, then invert Y: the clamp range is symmetric so the order is free
    assign w_dx = clamp_motion(signed'({i_header[HdrXSign], i_x_byte}));
    assign w_dy = -clamp_motion(signed'({i_header[HdrYSign], i_y_byte}));

    assign w_add_x = (ACC_WIDTH+1)'(i_sum_x) + (ACC_WIDTH+1)'(w_dx);
    assign w_add_y = (ACC_WIDTH+1)'(i_sum_y) + (ACC_WIDTH+1)'(w_dy);

    always_comb begin
        if (w_add_x[ACC_WIDTH] != w_add_x[ACC_WIDTH-1]) begin
            o_sum_x = w_add_x[ACC_WIDTH] ? AccMin : AccMax;
        end else begin
            o_sum_x = w_add_x[ACC_WIDTH-1:0];
        end
        if (w_add_y[ACC_WIDTH] != w_add_y[ACC_WIDTH-1]) begin
            o_sum_y = w_add_y[ACC_WIDTH] ? AccMin : AccMax;
        end else begin
            o_sum_y = w_add_y[ACC_WIDTH-1:0];
        end
    end

endmodule

>>> tb/ps2_mouse_packet_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_accumulator_tb
// Self-checking bench for the PS/2 mouse packet accumulator.
// ----------------------------------------------------------------------------
// Drives received bytes and queries into the input channel and checks every
// query report against a cycle-free model of the packet framing, the
// per-packet clamp and the saturating motion sums. A short directed pass
// covers the edge cases, a second pass drives the X sum to its top and the
// Y sum to its bottom, and a random pass mixes well-formed packets with noise
// and broken packets. Both sides of the block idle at random, with some calm
// stretches.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_accumulator_tb;
    import pma_pkg::*;

    localparam int     AccWidth = 16;
    localparam longint AccMax   = (longint'(1) << (AccWidth - 1)) - 1;
    localparam longint AccMin   = -AccMax - 1;
    localparam longint OutMax   = (longint'(1) << (OutWidth - 1)) - 1;
    localparam longint OutMin   = -OutMax - 1;
    localparam int     RandomItems = 120;
    localparam int     SegmentItems = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pma_stream_if #(.T(t_in_item))  in_if ();
    pma_stream_if #(.T(t_out_item)) out_if ();

    ps2_mouse_packet_accumulator #(
        .ACC_WIDTH (AccWidth)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    // Model state, mirrors the block after reset
    t_byte_pos  pkt_pos        = POS_HEADER;
    logic [7:0] pkt_header     = '0;
    logic [7:0] pkt_x          = '0;
    longint     acc_x          = 0;
    longint     acc_y          = 0;
    logic       held_left      = 1'b0;
    logic       held_right     = 1'b0;
    logic       motion_pending = 1'b0;

    t_out_item  motion_reports[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  sink_wait  = 0;
    bit  src_calm   = 1'b0;
    bit  sink_calm  = 1'b0;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Apply one accepted transaction; queries queue the report they should yield
    function automatic void advance_mouse_state(input t_in_item it);
        t_out_item rpt;
        longint    dx;
        longint    dy;
        rpt = '0;
        if (it.op == OP_QUERY) begin
            if (motion_pending) begin
                rpt.data_valid   = 1'b1;
                rpt.delta_x      = OutWidth'(clip(acc_x, OutMin, OutMax));
                rpt.delta_y      = OutWidth'(clip(acc_y, OutMin, OutMax));
                rpt.button_left  = held_left;
                rpt.button_right = held_right;
                acc_x            = 0;
                acc_y            = 0;
                motion_pending   = 1'b0;
            end
            motion_reports.push_back(rpt);
            return;
        end
        // anything not from the mouse port restarts framing
        if (!it.from_aux) begin
            pkt_pos = POS_HEADER;
            return;
        end
        case (pkt_pos)
            POS_X: begin
                pkt_x   = it.rx_byte;
                pkt_pos = POS_Y;
            end
            POS_Y: begin
                dx = longint'(pkt_x) - (pkt_header[HdrXSign] ? 256 : 0);
                dy = -(longint'(it.rx_byte) - (pkt_header[HdrYSign] ? 256 : 0));
                dx = clip(dx, longint'(MotionMin), longint'(MotionMax));
                dy = clip(dy, longint'(MotionMin), longint'(MotionMax));
                acc_x          = clip(acc_x + dx, AccMin, AccMax);
                acc_y          = clip(acc_y + dy, AccMin, AccMax);
                held_left      = pkt_header[HdrBtnLeft];
                held_right     = pkt_header[HdrBtnRight];
                motion_pending = 1'b1;
                pkt_pos        = POS_HEADER;
            end
            default: begin
                // drop a first byte that lacks the sync bit
                if (it.rx_byte[HdrSync]) begin
                    pkt_header = it.rx_byte;
                    pkt_pos    = POS_X;
                end
            end
        endcase
    endfunction

    function automatic t_in_item rx_item(input logic [7:0] b, input logic aux);
        t_in_item it;
        it.op       = OP_RX_BYTE;
        it.rx_byte  = b;
        it.from_aux = aux;
        return it;
    endfunction

    function automatic t_in_item query_item(input logic [7:0] b, input logic aux);
        t_in_item it;
        it.op       = OP_QUERY;
        it.rx_byte  = b;
        it.from_aux = aux;
        return it;
    endfunction

    function automatic logic [7:0] header_byte_of(input bit left, input bit right,
                                                  input bit x_neg, input bit y_neg);
        logic [7:0] h;
        h              = '0;
        h[HdrSync]     = 1'b1;
        h[HdrBtnLeft]  = left;
        h[HdrBtnRight] = right;
        h[HdrXSign]    = x_neg;
        h[HdrYSign]    = y_neg;
        return h;
    endfunction

    // Drop valid for a random gap, then present the item until accepted.
    // Valid stays high on return so a back-to-back item needs no extra edge.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        advance_mouse_state(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic aux);
        send_item(rx_item(b, aux));
    endtask

    // Payload bits of a query are don't-care; randomize them
    task automatic send_query();
        send_item(query_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_packet(input logic [7:0] h, input logic [7:0] x, input logic [7:0] y);
        send_byte(h, 1'b1);
        send_byte(x, 1'b1);
        send_byte(y, 1'b1);
    endtask

    // Wait on the clock before the first check so the caller's valid drop lands first
    task automatic wait_reports_drained();
        do @(posedge i_clk); while (motion_reports.size() != 0);
    endtask

    task automatic check_report(input t_out_item got);
        t_out_item want;
        if (motion_reports.size() == 0) begin
            $error("report with no query outstanding: data_valid %0b dx %0d dy %0d",
                   got.data_valid, $signed(got.delta_x), $signed(got.delta_y));
            mismatches++;
            return;
        end
        want = motion_reports.pop_front();
        if (got.data_valid !== want.data_valid) begin
            $error("data_valid: expected %0b, got %0b", want.data_valid, got.data_valid);
            mismatches++;
        end
        if (got.delta_x !== want.delta_x) begin
            $error("delta_x: expected %0d, got %0d",
                   $signed(want.delta_x), $signed(got.delta_x));
            mismatches++;
        end
        if (got.delta_y !== want.delta_y) begin
            $error("delta_y: expected %0d, got %0d",
                   $signed(want.delta_y), $signed(got.delta_y));
            mismatches++;
        end
        if (got.button_left !== want.button_left) begin
            $error("button_left: expected %0b, got %0b", want.button_left, got.button_left);
            mismatches++;
        end
        if (got.button_right !== want.button_right) begin
            $error("button_right: expected %0b, got %0b", want.button_right, got.button_right);
            mismatches++;
        end
    endtask

    // Report sink: check each transaction, then stall ready for a random count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_report(out_if.data);
                sink_wait = sink_calm ? 0 : $urandom_range(0, 6);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_directed_cases();
        // idle query reports all zeros whatever its payload bits say
        send_item(query_item(8'hFF, 1'b1));
        // X at 255 clamps to +127; Y raw +128 inverts to -128 and clamps to -127
        send_packet(header_byte_of(1'b1, 1'b1, 1'b0, 1'b0), 8'hFF, 8'h80);
        send_query();
        send_query();
        // header without sync is dropped, next byte starts the packet
        send_byte(8'hF7, 1'b1);
        // both raw values -256: X clamps to -127, inverted Y to +127
        send_packet(header_byte_of(1'b0, 1'b0, 1'b1, 1'b1), 8'h00, 8'h00);
        // non-auxiliary byte mid-packet restarts framing
        send_byte(header_byte_of(1'b1, 1'b0, 1'b0, 1'b0), 1'b1);
        send_byte(8'h05, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_packet(header_byte_of(1'b0, 1'b1, 1'b1, 1'b1), 8'hFF, 8'hFF);
        send_query();
        // query inside a packet does not disturb framing
        send_byte(header_byte_of(1'b1, 1'b0, 1'b0, 1'b1), 1'b1);
        send_query();
        send_byte(8'h10, 1'b1);
        send_byte(8'hF0, 1'b1);
        send_query();
        // zero motion still marks a packet as pending
        send_byte(8'h00, 1'b0);
        send_packet(header_byte_of(1'b0, 1'b0, 1'b0, 1'b0), 8'h00, 8'h00);
        send_query();
        send_query();
    endtask

    // Push X past the top of the 16-bit range and inverted Y past the bottom
    task automatic test_accumulator_saturation();
        src_calm = 1'b1;
        repeat (260) send_packet(header_byte_of(1'b1, 1'b0, 1'b0, 1'b0), 8'h7F, 8'h7F);
        send_query();
        src_calm = 1'b0;
    endtask

    task automatic maybe_query();
        if ($urandom_range(0, 9) == 0) begin
            send_query();
        end
    endtask

    task automatic test_random_traffic();
        int seg_start;
        int pick;
        logic [7:0] h;
        for (int seg = 0; seg < RandomItems / SegmentItems; seg++) begin
            src_calm  = (seg == 1) || (seg == 3);
            sink_calm = (seg == 2) || (seg == 3);
            seg_start = items_sent;
            while (items_sent - seg_start < SegmentItems) begin
                pick = $urandom_range(0, 99);
                h    = 8'($urandom_range(0, 255));
                h[HdrSync] = 1'b1;
                if (pick < 55) begin
                    // well-formed packet, sometimes with a query woven in
                    send_byte(h, 1'b1);
                    maybe_query();
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    maybe_query();
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end else if (pick < 72) begin
                    send_query();
                end else if (pick < 86) begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else begin
                    // broken packet: cut short by a controller byte
                    send_byte(h, 1'b1);
                    if ($urandom_range(0, 1) == 1) begin
                        send_byte(8'($urandom_range(0, 255)), 1'b1);
                    end
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            // hold off the sender until the sink has caught up
            if (seg == 1 || seg == 4) begin
                in_if.valid <= 1'b0;
                wait_reports_drained();
            end
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.data  = '0;
        i_rst_n     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_accumulator_saturation();
        test_random_traffic();
        in_if.valid <= 1'b0;
        wait_reports_drained();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: many times the slowest legal run
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
hdl/pma_pkg.sv
hdl/pma_stream_if.sv
hdl/pma_motion.sv
hdl/ps2_mouse_packet_accumulator.sv
tb/ps2_mouse_packet_accumulator_tb.sv
